>>> design/keyboard_scancode_fifo_core_macros.svh
// Assertion macros for the checker file of the scancode queue.
`ifndef KEYBOARD_SCANCODE_FIFO_CORE_MACROS_SVH
`define KEYBOARD_SCANCODE_FIFO_CORE_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define KSF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define KSF_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/ksf_pkg.sv
// Types and constants shared by the scancode queue modules.
package ksf_pkg;

	localparam logic [7:0] BREAK_BYTE = 8'hF0;
	localparam logic [7:0] NO_BYTE    = 8'h00;

	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] prefix_byte;
		logic [7:0] key_code;
		logic       release_req;
	} ksf_in_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       data_valid;
		logic [1:0] bytes_queued;
		logic       irq;
	} ksf_out_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_BRK  = 6'b000010,
		ST_PFX  = 6'b000100,
		ST_CODE = 6'b001000,
		ST_RD   = 6'b010000,
		ST_DONE = 6'b100000
	} ksf_state_t;

	typedef struct packed {
		logic load_item;
		logic push_brk;
		logic push_pfx;
		logic push_code;
		logic pop;
		logic load_result;
	} ksf_cmd_t;

endpackage

>>> design/ksf_dp.sv
// Datapath: item register, byte ring, ring indices and result register.
module ksf_dp
	import ksf_pkg::*;
#(
	parameter int RING_DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  ksf_cmd_t cmd,
	input  ksf_in_t  req_data,
	output ksf_out_t rsp_data
);

	localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

	logic [7:0]    ring_mem [RING_DEPTH];
	logic [IW-1:0] wr_idx_q;
	logic [IW-1:0] rd_idx_q;
	ksf_in_t       item_q;
	logic [1:0]    count_q;
	logic          hit_q;
	logic [7:0]    rd_byte_q;
	ksf_out_t      rsp_q;

	logic [IW-1:0] wr_next;
	logic [IW-1:0] rd_next;
	logic          full;
	logic          empty;
	logic          push_req;
	logic [7:0]    push_byte;
	logic          push_ok;

	assign wr_next = (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + 1'b1;
	assign rd_next = (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
	assign full    = (wr_next == rd_idx_q);
	assign empty   = (wr_idx_q == rd_idx_q);

	// One push step per cycle; each byte is tried on its own against a full ring.
	always_comb begin
		push_req  = 1'b0;
		push_byte = NO_BYTE;
		if (cmd.push_brk) begin
			push_req  = item_q.release_req;
			push_byte = BREAK_BYTE;
		end else if (cmd.push_pfx) begin
			push_req  = (item_q.prefix_byte != NO_BYTE);
			push_byte = item_q.prefix_byte;
		end else if (cmd.push_code) begin
			push_req  = (item_q.key_code != NO_BYTE);
			push_byte = item_q.key_code;
		end
	end

	assign push_ok = push_req && !full;

	always_ff @(posedge clk) begin
		if (push_ok)
			ring_mem[wr_idx_q] <= push_byte;
		if (cmd.pop)
			rd_byte_q <= ring_mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
		end else begin
			if (push_ok)
				wr_idx_q <= wr_next;
			if (cmd.pop && !empty)
				rd_idx_q <= rd_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q  <= req_data;
			count_q <= 2'd0;
			hit_q   <= 1'b0;
		end else begin
			if (push_ok)
				count_q <= count_q + 2'd1;
			if (cmd.pop)
				hit_q <= !empty;
		end
		if (cmd.load_result) begin
			rsp_q.read_data    <= (item_q.operation == OP_READ && hit_q) ? rd_byte_q : NO_BYTE;
			rsp_q.data_valid   <= (item_q.operation == OP_READ) && hit_q;
			rsp_q.bytes_queued <= (item_q.operation == OP_KEY) ? count_q : 2'd0;
			rsp_q.irq          <= (item_q.operation == OP_KEY) && (count_q != 2'd0);
		end
	end

	assign rsp_data = rsp_q;

endmodule

>>> design/ksf_ctrl.sv
// Controller: sequences push steps or the pop, then hands the result beat out.
module ksf_ctrl
	import ksf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_op,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output ksf_cmd_t cmd
);

	ksf_state_t state_q;
	ksf_state_t state_d;
	logic       rsp_valid_q;
	logic       slot_free;

	assign slot_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_item = 1'b1;
					state_d       = (req_op == OP_READ) ? ST_RD : ST_BRK;
				end
			end
			ST_BRK: begin
				cmd.push_brk = 1'b1;
				state_d      = ST_PFX;
			end
			ST_PFX: begin
				cmd.push_pfx = 1'b1;
				state_d      = ST_CODE;
			end
			ST_CODE: begin
				cmd.push_code = 1'b1;
				state_d       = ST_DONE;
			end
			ST_RD: begin
				cmd.pop = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register can take the beat
				if (slot_free) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_result)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

>>> design/keyboard_scancode_fifo_core.sv
// Emulated keyboard scancode queue: key events push bytes, reads pop one byte.
//
// Request channel (req_valid / req_stall / req_data): one beat is either a key
// event (operation 0) or a read (operation 1). A key event queues the break byte
// 0xF0 if release_req is set, then prefix_byte if nonzero, then key_code if
// nonzero; a byte that finds the ring full is dropped. The ring holds at most
// RING_DEPTH - 1 bytes.
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one beat per
// request, in order. irq is set when a key event queued at least one byte.
// Sequence: a key event's response beat goes valid after the break, prefix and
// code push steps (one byte slot each on the single write port of the ring),
// then the load; a read's after the registered ring read, then the load. A new
// request is taken once the previous one has reached the output register.
// Stall: the response register holds its beat while rsp_stall is high; a
// finished result waits in the controller until the register frees up, and
// req_stall stays high meanwhile.
// Reset: clears both ring indices (ring empty) and all control state; ring
// contents are left as they are.
module keyboard_scancode_fifo_core
	import ksf_pkg::*;
#(
	parameter int RING_DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  ksf_in_t  req_data,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output ksf_out_t rsp_data
);

	ksf_cmd_t cmd;

	ksf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req_data.operation),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	ksf_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_data (req_data),
		.rsp_data (rsp_data)
	);

endmodule

>>> design/ksf_checker.sv
// Port-level checker for the scancode queue, bound to the top level.
`include "keyboard_scancode_fifo_core_macros.svh"

module ksf_checker
	import ksf_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_stall,
	input logic     rsp_valid,
	input logic     rsp_stall,
	input ksf_out_t rsp_data
);

	`KSF_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "response beat changed while stalled")
	`KSF_ASSERT(a_busy_after_accept, req_valid && !req_stall |=> req_stall, "request taken while previous one in flight")
	`KSF_ASSERT(a_irq_match, rsp_valid |-> (rsp_data.irq == (rsp_data.bytes_queued != 2'd0)), "irq disagrees with queued count")
	`KSF_ASSERT(a_read_key_excl, rsp_valid |-> !(rsp_data.data_valid && (rsp_data.bytes_queued != 2'd0)), "read and key results mixed")
	`KSF_ASSERT(a_empty_read_zero, rsp_valid && !rsp_data.data_valid |-> (rsp_data.read_data == 8'h00), "nonzero data without data_valid")

endmodule

bind keyboard_scancode_fifo_core ksf_checker u_ksf_checker (.*);

>>> tb/sv/keyboard_scancode_fifo_core_test.sv
// Self-checking testbench for the keyboard scancode queue core.
`timescale 1ns / 100ps

module keyboard_scancode_fifo_core_test;
	import ksf_pkg::*;

	localparam int RING_SLOTS   = 16;
	localparam int QUIET_LIMIT  = 2000;
	localparam int LONG_HOLD    = 150;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS  = 10;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	ksf_in_t  req_data  = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	ksf_out_t rsp_data;

	// Scancode queue as the testbench sees it
	logic [7:0] queued_bytes [RING_SLOTS];
	int         push_slot = 0;
	int         pop_slot  = 0;

	ksf_out_t awaited_rsp [$];

	bit sender_idle   = 1'b1;
	bit receiver_idle = 1'b1;
	bit hold_pending  = 1'b0;
	int mismatch_count = 0;
	int quiet_cycles   = 0;

	keyboard_scancode_fifo_core #(
		.RING_DEPTH(RING_SLOTS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned enqueue_byte(input logic [7:0] value);
		int next_slot;
		next_slot = (push_slot + 1) % RING_SLOTS;
		// drop the byte when it would close the last free slot
		if (next_slot == pop_slot)
			return 0;
		queued_bytes[push_slot] = value;
		push_slot = next_slot;
		return 1;
	endfunction

	function automatic ksf_out_t predict_scancode_response(input ksf_in_t item);
		ksf_out_t    result;
		int unsigned taken;
		result = '0;
		taken  = 0;
		if (item.operation == OP_READ) begin
			if (pop_slot != push_slot) begin
				result.read_data  = queued_bytes[pop_slot];
				result.data_valid = 1'b1;
				pop_slot = (pop_slot + 1) % RING_SLOTS;
			end
		end else begin
			if (item.release_req)
				taken += enqueue_byte(BREAK_BYTE);
			if (item.prefix_byte != NO_BYTE)
				taken += enqueue_byte(item.prefix_byte);
			if (item.key_code != NO_BYTE)
				taken += enqueue_byte(item.key_code);
			result.bytes_queued = taken[1:0];
			result.irq          = (taken != 0);
		end
		return result;
	endfunction

	function automatic ksf_in_t key_event(input logic [7:0] prefix, input logic [7:0] code,
			input logic released);
		ksf_in_t item;
		item.operation   = OP_KEY;
		item.prefix_byte = prefix;
		item.key_code    = code;
		item.release_req = released;
		return item;
	endfunction

	function automatic ksf_in_t read_request();
		return key_event(NO_BYTE, NO_BYTE, 1'b0) | {OP_READ, 17'b0};
	endfunction

	function automatic ksf_in_t random_item(input int read_pct);
		ksf_in_t item;
		item.prefix_byte = 8'($urandom_range(0, 255));
		item.key_code    = 8'($urandom_range(0, 255));
		item.release_req = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < read_pct) begin
			item.operation = OP_READ;
		end else begin
			item.operation = OP_KEY;
			// most key events carry no prefix or the extended one
			case ($urandom_range(0, 9))
				0, 1, 2, 3: item.prefix_byte = NO_BYTE;
				4, 5, 6:    item.prefix_byte = 8'hE0;
				default:    ;
			endcase
			if ($urandom_range(0, 9) == 0)
				item.key_code = NO_BYTE;
		end
		return item;
	endfunction

	task automatic send_beat(input ksf_in_t item);
		req_data  <= item;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		awaited_rsp.push_back(predict_scancode_response(item));
		if (sender_idle && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic check_response(input ksf_out_t got);
		ksf_out_t want;
		if (awaited_rsp.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("unexpected beat: data=%h valid=%b queued=%0d irq=%b",
					got.read_data, got.data_valid, got.bytes_queued, got.irq);
		end else begin
			want = awaited_rsp.pop_front();
			if (got.read_data !== want.read_data || got.data_valid !== want.data_valid ||
					got.bytes_queued !== want.bytes_queued || got.irq !== want.irq) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("mismatch: expected data=%h valid=%b queued=%0d irq=%b, got data=%h valid=%b queued=%0d irq=%b",
						want.read_data, want.data_valid, want.bytes_queued, want.irq,
						got.read_data, got.data_valid, got.bytes_queued, got.irq);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			check_response(rsp_data);
	end

	// Receiver: short random stalls, or one long hold when requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if (receiver_idle && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic test_empty_read();
		send_beat(read_request());
	endtask

	task automatic test_key_sequences();
		send_beat(key_event(8'hE0, 8'h74, 1'b1));
		repeat (3) send_beat(read_request());
		// released unknown key queues the break byte alone
		send_beat(key_event(NO_BYTE, NO_BYTE, 1'b1));
		send_beat(key_event(NO_BYTE, NO_BYTE, 1'b0));
		send_beat(key_event(8'hFF, 8'hFF, 1'b0));
		send_beat(key_event(NO_BYTE, 8'h01, 1'b0));
		repeat (5) send_beat(read_request());
	endtask

	task automatic test_ring_full();
		send_beat(key_event(8'hFF, 8'h01, 1'b1));
		send_beat(key_event(8'hE0, 8'h80, 1'b1));
		send_beat(key_event(8'hE0, 8'hFF, 1'b1));
		send_beat(key_event(8'h01, 8'h7F, 1'b1));
		send_beat(key_event(8'h80, 8'h55, 1'b1));
		// ring is full: drop the whole event, then take only its first byte
		send_beat(key_event(8'hE0, 8'h1C, 1'b1));
		send_beat(read_request());
		send_beat(key_event(8'hE0, 8'h1C, 1'b1));
	endtask

	task automatic test_random_traffic();
		int read_pct;
		for (int chunk = 0; chunk < 10; chunk++) begin
			case ($urandom_range(0, 2))
				0:       read_pct = 25;
				1:       read_pct = 50;
				default: read_pct = 75;
			endcase
			sender_idle   = 1'($urandom_range(0, 1));
			receiver_idle = 1'($urandom_range(0, 1));
			repeat (100) send_beat(random_item(read_pct));
		end
	endtask

	task automatic test_output_hold_off();
		sender_idle  = 1'b0;
		hold_pending = 1'b1;
		repeat (40) send_beat(random_item(50));
	endtask

	task automatic test_back_to_back();
		sender_idle   = 1'b0;
		receiver_idle = 1'b0;
		repeat (250) send_beat(random_item(50));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_read();
		test_key_sequences();
		test_ring_full();
		test_random_traffic();
		test_output_hold_off();
		test_back_to_back();
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		// keep watching the response port to catch stray beats
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && awaited_rsp.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+design
design/ksf_pkg.sv
design/ksf_dp.sv
design/ksf_ctrl.sv
design/keyboard_scancode_fifo_core.sv
design/ksf_checker.sv
tb/sv/keyboard_scancode_fifo_core_test.sv
